// ===== hw/rtl/sbpe_pkg.sv =====
// Shared types and constants for the servo bus packet engine.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package sbpe_pkg;

  // Instruction codes as they arrive on the input; sent on the wire plus INSTR_OFFSET.
  typedef enum logic [1:0] {
    INSTR_READ      = 2'd0,
    INSTR_WRITE     = 2'd1,
    INSTR_REG_WRITE = 2'd2,
    INSTR_ACTION    = 2'd3
  } instr_e;

  typedef enum logic {
    FUNC_COMMAND = 1'b0,
    FUNC_STATUS  = 1'b1
  } func_e;

  typedef enum logic {
    KIND_TX_BYTE = 1'b0,
    KIND_REPLY   = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_BROADCAST_ID = 1'b0,
    CFG_LENGTH_BASE  = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] HEADER_BYTE     = 8'hFF;
  localparam logic [7:0] INSTR_OFFSET    = 8'd2;
  localparam logic [8:0] STATUS_BASE     = 9'd6;
  localparam logic [8:0] STATUS_LOW_POS  = 9'd5;
  localparam logic [8:0] STATUS_HIGH_POS = 9'd6;
  localparam logic [7:0] BROADCAST_RESET = 8'd254;
  localparam logic [7:0] LENGTH_RESET    = 8'd2;
  localparam int         PKT_MAX         = 9;

  typedef logic [PKT_MAX-1:0][7:0] pkt_t;
  typedef logic [3:0]              pkt_cnt_t;

  // Packet bytes, byte 0 first on the wire, with the number of valid bytes.
  typedef struct packed {
    pkt_t     bytes;
    pkt_cnt_t count;
  } frame_t;

  // A completed reply raised by the item being accepted.
  typedef struct packed {
    logic        valid;
    logic [15:0] value;
  } reply_t;

endpackage

`default_nettype wire

// ===== hw/rtl/servo_bus_packet_engine_core.sv =====
// Servo bus packet engine: frames command packets and counts status bytes.
// The first result of an item is offered in the cycle after its transfer.
// Throughput: a command yields 6 to 10 results, one per cycle while the output
// is not stalled, set by the result buffer; the next item is taken in the cycle
// the last result transfers out. Reset clears all control state and loads the
// configuration registers with broadcast id 254 and length base 2.
`default_nettype none

module servo_bus_packet_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  servo_id_i,
  input  wire logic [1:0]  instruction_i,
  input  wire logic [7:0]  register_address_i,
  input  wire logic        register_is_word_i,
  input  wire logic [15:0] param_i,
  input  wire logic [7:0]  rx_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       tx_data_o,
  output logic             last_o,
  output logic [15:0]      reply_value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic             accept;
  logic             pop;
  logic             awaiting;
  logic [7:0]       broadcast_id_q;
  logic [7:0]       length_base_q;
  sbpe_pkg::frame_t frame_cmd;
  sbpe_pkg::frame_t frame_load;
  sbpe_pkg::reply_t reply;
  sbpe_pkg::func_e  func;
  sbpe_pkg::instr_e instr;

  assign func        = sbpe_pkg::func_e'(func_i);
  assign instr       = sbpe_pkg::instr_e'(instruction_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      broadcast_id_q <= sbpe_pkg::BROADCAST_RESET;
      length_base_q  <= sbpe_pkg::LENGTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sbpe_pkg::cfg_idx_e'(cfg_index_i))
        sbpe_pkg::CFG_BROADCAST_ID: broadcast_id_q <= cfg_data_i;
        sbpe_pkg::CFG_LENGTH_BASE:  length_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The buffer frees up in the cycle its final result transfers.
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = out_valid_o && !(pop && last_o);
  assign accept     = in_valid_i && !in_stall_o;

  sbpe_framer u_framer (
    .instruction_i      (instr),
    .servo_id_i         (servo_id_i),
    .register_address_i (register_address_i),
    .register_is_word_i (register_is_word_i),
    .param_i            (param_i),
    .length_base_i      (length_base_q),
    .frame_o            (frame_cmd)
  );

  sbpe_status u_status (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .func_i             (func),
    .instruction_i      (instr),
    .servo_id_i         (servo_id_i),
    .register_is_word_i (register_is_word_i),
    .param_lo_i         (param_i[7:0]),
    .rx_data_i          (rx_data_i),
    .broadcast_id_i     (broadcast_id_q),
    .reply_o            (reply),
    .awaiting_o         (awaiting)
  );

  // A status byte carries no packet bytes, only a possible reply.
  always_comb begin
    frame_load = frame_cmd;
    if (func == sbpe_pkg::FUNC_STATUS) begin
      frame_load.count = '0;
    end
  end

  sbpe_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .frame_i       (frame_load),
    .reply_i       (reply),
    .pop_i         (pop),
    .valid_o       (out_valid_o),
    .kind_o        (kind_o),
    .tx_data_o     (tx_data_o),
    .last_o        (last_o),
    .reply_value_o (reply_value_o)
  );

  // With results pending, an item is only taken as its final result drains.
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_o) |-> (last_o && !out_stall_i))
    else $error("item taken while earlier results still pending");

  // Reply results are always final and carry no transmit byte.
  a_reply_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (last_o && tx_data_o == 8'h00))
    else $error("reply result malformed");

  // A command to the broadcast id leaves nothing awaited and offers a packet next.
  a_broadcast_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == sbpe_pkg::FUNC_COMMAND && servo_id_i == broadcast_id_q)
      |=> (!awaiting && out_valid_o && !kind_o && tx_data_o == sbpe_pkg::HEADER_BYTE))
    else $error("broadcast command left status pending");

  // A status byte that is ignored while idle raises no result.
  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == sbpe_pkg::FUNC_STATUS && !awaiting) |=> !out_valid_o)
    else $error("status byte while idle produced a result");

endmodule

`default_nettype wire

// ===== hw/rtl/sbpe_framer.sv =====
// Builds the instruction packet and its checksum for one command item.
// Pure combinational logic; depends on sbpe_pkg.
`default_nettype none

module sbpe_framer (
  input  wire sbpe_pkg::instr_e instruction_i,
  input  wire logic [7:0]       servo_id_i,
  input  wire logic [7:0]       register_address_i,
  input  wire logic             register_is_word_i,
  input  wire logic [15:0]      param_i,
  input  wire logic [7:0]       length_base_i,
  output sbpe_pkg::frame_t      frame_o
);

  logic [7:0] len;
  logic [7:0] code;
  logic [7:0] sum;
  logic [7:0] chk;
  logic       is_action;
  logic       has_high;

  assign is_action = (instruction_i == sbpe_pkg::INSTR_ACTION);
  // Only write and reg_write carry the high data byte.
  assign has_high  = register_is_word_i && !is_action &&
                     (instruction_i != sbpe_pkg::INSTR_READ);
  assign code      = {6'd0, instruction_i} + sbpe_pkg::INSTR_OFFSET;

  always_comb begin
    case (instruction_i)
      sbpe_pkg::INSTR_READ:   len = length_base_i + 8'd2;
      sbpe_pkg::INSTR_ACTION: len = length_base_i;
      default:                len = length_base_i + (register_is_word_i ? 8'd3 : 8'd2);
    endcase
  end

  always_comb begin
    sum = servo_id_i + len + code;
    if (!is_action) begin
      sum = sum + register_address_i + param_i[7:0];
    end
    if (has_high) begin
      sum = sum + param_i[15:8];
    end
  end

  assign chk = ~sum;

  always_comb begin
    frame_o.bytes[0] = sbpe_pkg::HEADER_BYTE;
    frame_o.bytes[1] = sbpe_pkg::HEADER_BYTE;
    frame_o.bytes[2] = servo_id_i;
    frame_o.bytes[3] = len;
    frame_o.bytes[4] = code;
    frame_o.bytes[5] = is_action ? chk : register_address_i;
    frame_o.bytes[6] = param_i[7:0];
    frame_o.bytes[7] = has_high ? param_i[15:8] : chk;
    frame_o.bytes[8] = chk;
    if (is_action) begin
      frame_o.count = 4'd6;
    end else if (has_high) begin
      frame_o.count = 4'd9;
    end else begin
      frame_o.count = 4'd8;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbpe_status.sv =====
// Tracks the pending command, counts received status bytes and
// replies at the expected count or on broadcast; uses sbpe_pkg.
`default_nettype none

module sbpe_status (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire sbpe_pkg::func_e  func_i,
  input  wire sbpe_pkg::instr_e instruction_i,
  input  wire logic [7:0]       servo_id_i,
  input  wire logic             register_is_word_i,
  input  wire logic [7:0]       param_lo_i,
  input  wire logic [7:0]       rx_data_i,
  input  wire logic [7:0]       broadcast_id_i,
  output sbpe_pkg::reply_t      reply_o,
  output logic                  awaiting_o
);

  logic       awaiting_q, awaiting_d;
  logic [8:0] count_q, count_d;
  logic [8:0] expected_q, expected_d;
  logic [7:0] low_q, low_d;
  logic [7:0] high_q, high_d;
  logic       is_read_q, is_read_d;
  logic       is_word_q, is_word_d;
  logic [8:0] count_inc;

  assign count_inc = count_q + 9'd1;

  always_comb begin
    awaiting_d     = awaiting_q;
    count_d        = count_q;
    expected_d     = expected_q;
    low_d          = low_q;
    high_d         = high_q;
    is_read_d      = is_read_q;
    is_word_d      = is_word_q;
    reply_o.valid  = 1'b0;
    if (accept_i) begin
      if (func_i == sbpe_pkg::FUNC_COMMAND) begin
        is_read_d  = (instruction_i == sbpe_pkg::INSTR_READ);
        is_word_d  = register_is_word_i;
        count_d    = '0;
        expected_d = is_read_d ? sbpe_pkg::STATUS_BASE + {1'b0, param_lo_i}
                               : sbpe_pkg::STATUS_BASE;
        awaiting_d = (servo_id_i != broadcast_id_i);
        reply_o.valid = !awaiting_d;
      end else if (awaiting_q) begin
        if (count_q == sbpe_pkg::STATUS_LOW_POS) begin
          low_d = rx_data_i;
        end else if (count_q == sbpe_pkg::STATUS_HIGH_POS) begin
          high_d = rx_data_i;
        end
        count_d = count_inc;
        if (count_inc == expected_q) begin
          awaiting_d    = 1'b0;
          count_d       = '0;
          reply_o.valid = 1'b1;
        end
      end
    end
    // The reply reads the updated pending flags and status bytes.
    if (!is_read_d) begin
      reply_o.value = '0;
    end else if (is_word_d) begin
      reply_o.value = {high_d, low_d};
    end else begin
      reply_o.value = {8'd0, low_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      count_q    <= '0;
      expected_q <= '0;
      low_q      <= '0;
      high_q     <= '0;
      is_read_q  <= 1'b0;
      is_word_q  <= 1'b0;
    end else begin
      awaiting_q <= awaiting_d;
      count_q    <= count_d;
      expected_q <= expected_d;
      low_q      <= low_d;
      high_q     <= high_d;
      is_read_q  <= is_read_d;
      is_word_q  <= is_word_d;
    end
  end

  assign awaiting_o = awaiting_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbpe_emit.sv =====
// Result buffer: holds one item's packet bytes and reply and shifts them out.
// One result per transfer on the output side; depends on sbpe_pkg.
`default_nettype none

module sbpe_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sbpe_pkg::frame_t frame_i,
  input  wire sbpe_pkg::reply_t reply_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic                  kind_o,
  output logic [7:0]            tx_data_o,
  output logic                  last_o,
  output logic [15:0]           reply_value_o
);

  sbpe_pkg::pkt_t     bytes_q, bytes_d;
  sbpe_pkg::pkt_cnt_t cnt_q, cnt_d;
  logic               reply_q, reply_d;
  logic [15:0]        value_q, value_d;

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    reply_d = reply_q;
    value_d = value_q;
    if (load_i) begin
      bytes_d = frame_i.bytes;
      cnt_d   = frame_i.count;
      reply_d = reply_i.valid;
      value_d = reply_i.value;
    end else if (pop_i) begin
      if (cnt_q != '0) begin
        bytes_d = sbpe_pkg::pkt_t'({8'h00, bytes_q[sbpe_pkg::PKT_MAX-1:1]});
        cnt_d   = cnt_q - 4'd1;
      end else begin
        reply_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      reply_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      reply_q <= reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    value_q <= value_d;
  end

  always_comb begin
    valid_o = (cnt_q != '0) || reply_q;
    if (cnt_q != '0) begin
      kind_o        = sbpe_pkg::KIND_TX_BYTE;
      tx_data_o     = bytes_q[0];
      last_o        = (cnt_q == 4'd1) && !reply_q;
      reply_value_o = '0;
    end else begin
      kind_o        = sbpe_pkg::KIND_REPLY;
      tx_data_o     = '0;
      last_o        = 1'b1;
      reply_value_o = value_q;
    end
  end

endmodule

`default_nettype wire
